FILE: design/vcr_pkg.sv
// ----------------------------------------------------------------------------
// vcr_pkg
// Shared types and constants for the visual colour resolve unit.
// ----------------------------------------------------------------------------
package vcr_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam int DIV_STEPS    = CHANNEL_BITS;
    localparam int LANE_STAGES  = 2 * DIV_STEPS + 2;
    localparam int GRAY_STAGES  = 2;
    localparam int PIPE_STAGES  = GRAY_STAGES + LANE_STAGES;
    localparam int SUM_BITS     = 23;
    localparam int GRAY_SHIFT   = 30;
    localparam logic [23:0] GRAY_RECIP = 24'd10737419;

    localparam logic [2:0] CLS_STATIC_GRAY  = 3'd0;
    localparam logic [2:0] CLS_GRAY_SCALE   = 3'd1;
    localparam logic [2:0] CLS_STATIC_COLOR = 3'd2;
    localparam logic [2:0] CLS_PSEUDO       = 3'd3;
    localparam logic [2:0] CLS_TRUE         = 3'd4;
    localparam logic [2:0] CLS_DIRECT       = 3'd5;

    localparam logic [2:0] REG_CLASS     = 3'd0;
    localparam logic [2:0] REG_RGB_BITS  = 3'd1;
    localparam logic [2:0] REG_GRAY_ENT  = 3'd2;
    localparam logic [2:0] REG_RED_MAX   = 3'd3;
    localparam logic [2:0] REG_GREEN_MAX = 3'd4;
    localparam logic [2:0] REG_BLUE_MAX  = 3'd5;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    typedef struct packed {
        logic  use_gray;
        logic  use_levels;
        chan_t top;
    } lane_ctl_t;

endpackage

FILE: design/vcr_div.sv
// ----------------------------------------------------------------------------
// vcr_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in one channel word (upper dividend half below the divisor).
// ----------------------------------------------------------------------------
module vcr_div
    import vcr_pkg::*;
(
    input  logic                        aclk,
    input  logic [DIV_STEPS-1:0]        en,
    input  logic [2*CHANNEL_BITS-1:0]   dividend,
    input  chan_t                       divisor,
    output chan_t                       quotient
);

    chan_t rem_reg [DIV_STEPS];
    chan_t quo_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        chan_t                 rem_in;
        chan_t                 quo_in;
        logic [CHANNEL_BITS:0] trial;
        logic                  take;

        if (k == 0) begin : g_first
            assign rem_in = dividend[2*CHANNEL_BITS-1:CHANNEL_BITS];
            assign quo_in = dividend[CHANNEL_BITS-1:0];
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in, quo_in[CHANNEL_BITS-1]};
        assign take  = trial >= {1'b0, divisor};

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= take ? CHANNEL_BITS'(trial - {1'b0, divisor})
                                   : trial[CHANNEL_BITS-1:0];
                quo_reg[k] <= {quo_in[CHANNEL_BITS-2:0], take};
            end
        end
    end

    assign quotient = quo_reg[DIV_STEPS-1];

endmodule

FILE: design/vcr_gray.sv
// ----------------------------------------------------------------------------
// vcr_gray
// Front merge stage: weighted gray of the three channels (30/59/11 over 100),
// with the channels delayed alongside.
// ----------------------------------------------------------------------------
module vcr_gray
    import vcr_pkg::*;
(
    input  logic                   aclk,
    input  logic [GRAY_STAGES-1:0] en,
    input  chan_t                  red_in,
    input  chan_t                  green_in,
    input  chan_t                  blue_in,
    output chan_t                  red_out,
    output chan_t                  green_out,
    output chan_t                  blue_out,
    output chan_t                  gray_out
);

    logic [SUM_BITS-1:0]   sum_next;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [SUM_BITS+23:0]  prod;
    chan_t                 r0_reg, g0_reg, b0_reg;
    chan_t                 r1_reg, g1_reg, b1_reg, gray_reg;

    assign sum_next = SUM_BITS'(red_in)   * SUM_BITS'(30)
                    + SUM_BITS'(green_in) * SUM_BITS'(59)
                    + SUM_BITS'(blue_in)  * SUM_BITS'(11);
    assign prod = (SUM_BITS+24)'(sum_reg) * (SUM_BITS+24)'(GRAY_RECIP);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sum_reg <= sum_next;
            r0_reg  <= red_in;
            g0_reg  <= green_in;
            b0_reg  <= blue_in;
        end
        if (en[1]) begin
            gray_reg <= prod[GRAY_SHIFT+CHANNEL_BITS-1:GRAY_SHIFT];
            r1_reg   <= r0_reg;
            g1_reg   <= g0_reg;
            b1_reg   <= b0_reg;
        end
    end

    assign red_out   = r1_reg;
    assign green_out = g1_reg;
    assign blue_out  = b1_reg;
    assign gray_out  = gray_reg;

endmodule

FILE: design/vcr_lane.sv
// ----------------------------------------------------------------------------
// vcr_lane
// One channel lane: optional level quantisation, then RGB-bit quantisation,
// each rescaled to full scale through a pipelined divider.
// ----------------------------------------------------------------------------
module vcr_lane
    import vcr_pkg::*;
(
    input  logic                   aclk,
    input  logic [LANE_STAGES-1:0] en,
    input  lane_ctl_t              ctl,
    input  logic [4:0]             rgb_bits,
    input  chan_t                  chan_in,
    input  chan_t                  gray_in,
    output chan_t                  chan_out
);

    chan_t                      v;
    logic [CHANNEL_BITS:0]      levels;
    logic [2*CHANNEL_BITS:0]    prod;
    chan_t                      q_reg, v_reg;
    logic                       lvl_reg;
    chan_t                      v_dly_reg [DIV_STEPS];
    logic                       lvl_dly_reg [DIV_STEPS];
    chan_t                      y;
    chan_t                      w;
    chan_t                      s;
    logic [4:0]                 sh;
    logic [CHANNEL_BITS:0]      pow;
    chan_t                      d;
    logic [2*CHANNEL_BITS-1:0]  x_next, x_reg;

    assign v      = ctl.use_gray ? gray_in : chan_in;
    assign levels = {1'b0, ctl.top} + (CHANNEL_BITS+1)'(1);
    assign prod   = (2*CHANNEL_BITS+1)'(v) * (2*CHANNEL_BITS+1)'(levels);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            q_reg   <= prod[2*CHANNEL_BITS-1:CHANNEL_BITS];
            v_reg   <= v;
            lvl_reg <= ctl.use_levels;
        end
    end

    vcr_div u_div_lvl (
        .aclk     (aclk),
        .en       (en[DIV_STEPS:1]),
        .dividend ({q_reg, CHANNEL_BITS'(0)} - {CHANNEL_BITS'(0), q_reg}),
        .divisor  (ctl.top),
        .quotient (y)
    );

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en[k+1]) begin
                v_dly_reg[k]   <= (k == 0) ? v_reg   : v_dly_reg[(k == 0) ? 0 : k-1];
                lvl_dly_reg[k] <= (k == 0) ? lvl_reg : lvl_dly_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign w      = lvl_dly_reg[DIV_STEPS-1] ? y : v_dly_reg[DIV_STEPS-1];
    assign sh     = 5'(CHANNEL_BITS) - rgb_bits;
    assign s      = w >> sh;
    assign x_next = {s, CHANNEL_BITS'(0)} - {CHANNEL_BITS'(0), s};
    assign pow    = (CHANNEL_BITS+1)'(1) << rgb_bits;
    assign d      = CHANNEL_BITS'(pow - (CHANNEL_BITS+1)'(1));

    always_ff @(posedge aclk) begin
        if (en[DIV_STEPS+1]) begin
            x_reg <= x_next;
        end
    end

    vcr_div u_div_bits (
        .aclk     (aclk),
        .en       (en[2*DIV_STEPS+1:DIV_STEPS+2]),
        .dividend (x_reg),
        .divisor  (d),
        .quotient (chan_out)
    );

endmodule

FILE: design/visual_color_resolve_unit.sv
// ----------------------------------------------------------------------------
// visual_color_resolve_unit
// Resolves a requested 16-bit RGB colour to the colour a visual can show.
// ----------------------------------------------------------------------------
// Takes one beat per cycle unless every stage is full and m_ready is low, and
// holds up to 36 beats in flight. The pipeline is the two 16-stage restoring
// division pipelines in each channel lane, the register in front of each, and
// the two gray stages in front; the last divider stage is the output register,
// so input stays ready while a result waits unless every stage is full.
// Registers must be written by the user through cfg_we/cfg_index/cfg_wdata
// only while no beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module visual_color_resolve_unit
    import vcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_red_in,
    input  logic [15:0] s_green_in,
    input  logic [15:0] s_blue_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_red_out,
    output logic [15:0] m_green_out,
    output logic [15:0] m_blue_out
);

    logic [2:0]             class_reg;
    logic [4:0]             rgb_bits_reg;
    chan_t                  gray_top_reg;
    chan_t                  red_max_reg, green_max_reg, blue_max_reg;
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] en;
    lane_ctl_t              ctl_r, ctl_g, ctl_b;
    chan_t                  r_d, g_d, b_d, gray;

    always_comb begin
        for (int i = 0; i < PIPE_STAGES; i++) begin
            en[i] = m_ready
                  | ~&(valid_reg | PIPE_STAGES'((PIPE_STAGES+1)'(1) << i) - PIPE_STAGES'(1));
        end
    end

    always_comb begin
        valid_next = valid_reg;
        for (int i = 0; i < PIPE_STAGES; i++) begin
            if (en[i]) begin
                valid_next[i] = (i == 0) ? s_valid : valid_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            class_reg     <= CLS_PSEUDO;
            rgb_bits_reg  <= 5'd8;
            gray_top_reg  <= 16'd255;
            red_max_reg   <= 16'd255;
            green_max_reg <= 16'd255;
            blue_max_reg  <= 16'd255;
        end else begin
            valid_reg <= valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_CLASS: begin
                        class_reg <= cfg_wdata[2:0];
                    end
                    REG_RGB_BITS: begin
                        if (cfg_wdata[4:0] == 5'd0) begin
                            rgb_bits_reg <= 5'd1;
                        end else if (cfg_wdata[4:0] > 5'd16) begin
                            rgb_bits_reg <= 5'd16;
                        end else begin
                            rgb_bits_reg <= cfg_wdata[4:0];
                        end
                    end
                    REG_GRAY_ENT: begin
                        if (cfg_wdata < 17'd2) begin
                            gray_top_reg <= 16'd1;
                        end else if (cfg_wdata > 17'd65536) begin
                            gray_top_reg <= 16'hFFFF;
                        end else begin
                            gray_top_reg <= 16'(cfg_wdata - 17'd1);
                        end
                    end
                    REG_RED_MAX: begin
                        red_max_reg <= (cfg_wdata[15:0] == '0) ? 16'd1 : cfg_wdata[15:0];
                    end
                    REG_GREEN_MAX: begin
                        green_max_reg <= (cfg_wdata[15:0] == '0) ? 16'd1 : cfg_wdata[15:0];
                    end
                    REG_BLUE_MAX: begin
                        blue_max_reg <= (cfg_wdata[15:0] == '0) ? 16'd1 : cfg_wdata[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        ctl_r = '{use_gray: 1'b0, use_levels: 1'b1, top: red_max_reg};
        ctl_g = '{use_gray: 1'b0, use_levels: 1'b1, top: green_max_reg};
        ctl_b = '{use_gray: 1'b0, use_levels: 1'b1, top: blue_max_reg};
        case (class_reg)
            CLS_PSEUDO, CLS_DIRECT: begin
                ctl_r.use_levels = 1'b0;
                ctl_g.use_levels = 1'b0;
                ctl_b.use_levels = 1'b0;
            end
            CLS_GRAY_SCALE: begin
                ctl_r = '{use_gray: 1'b1, use_levels: 1'b0, top: red_max_reg};
                ctl_g = '{use_gray: 1'b1, use_levels: 1'b0, top: green_max_reg};
                ctl_b = '{use_gray: 1'b1, use_levels: 1'b0, top: blue_max_reg};
            end
            CLS_STATIC_GRAY: begin
                ctl_r = '{use_gray: 1'b1, use_levels: 1'b1, top: gray_top_reg};
                ctl_g = '{use_gray: 1'b1, use_levels: 1'b1, top: gray_top_reg};
                ctl_b = '{use_gray: 1'b1, use_levels: 1'b1, top: gray_top_reg};
            end
            default: begin
            end
        endcase
    end

    vcr_gray u_gray (
        .aclk      (aclk),
        .en        (en[GRAY_STAGES-1:0]),
        .red_in    (s_red_in),
        .green_in  (s_green_in),
        .blue_in   (s_blue_in),
        .red_out   (r_d),
        .green_out (g_d),
        .blue_out  (b_d),
        .gray_out  (gray)
    );

    vcr_lane u_lane_r (
        .aclk     (aclk),
        .en       (en[PIPE_STAGES-1:GRAY_STAGES]),
        .ctl      (ctl_r),
        .rgb_bits (rgb_bits_reg),
        .chan_in  (r_d),
        .gray_in  (gray),
        .chan_out (m_red_out)
    );

    vcr_lane u_lane_g (
        .aclk     (aclk),
        .en       (en[PIPE_STAGES-1:GRAY_STAGES]),
        .ctl      (ctl_g),
        .rgb_bits (rgb_bits_reg),
        .chan_in  (g_d),
        .gray_in  (gray),
        .chan_out (m_green_out)
    );

    vcr_lane u_lane_b (
        .aclk     (aclk),
        .en       (en[PIPE_STAGES-1:GRAY_STAGES]),
        .ctl      (ctl_b),
        .rgb_bits (rgb_bits_reg),
        .chan_in  (b_d),
        .gray_in  (gray),
        .chan_out (m_blue_out)
    );

    assign s_ready = en[0];
    assign m_valid = valid_reg[PIPE_STAGES-1];

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg && !m_ready))
        else $error("input stalled with a free stage");

    a_rgb_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rgb_bits_reg >= 5'd1) && (rgb_bits_reg <= 5'd16))
        else $error("rgb_bits register out of range");

    a_gray_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (class_reg == CLS_STATIC_GRAY || class_reg == CLS_GRAY_SCALE))
        |-> (m_red_out == m_green_out && m_green_out == m_blue_out))
        else $error("gray class channels differ");
`endif

endmodule
